// ===== src/gqls_pkg.sv =====
// Shared constants, register codes and control structs for the gridworld Q-learning step.
// Used by the config bank, controller, datapath, top level and checker.
package gqls_pkg;

    // Sizing
    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int Q_BITS     = 24;
    localparam int N_ACT      = 4;
    localparam int N_CELLS    = MAX_WIDTH * MAX_HEIGHT;
    localparam int CELL_W     = $clog2(N_CELLS);
    localparam int ROW_W      = N_ACT * Q_BITS;
    localparam int X_W        = $clog2(MAX_WIDTH);
    localparam int Y_W        = $clog2(MAX_HEIGHT);

    // Register field widths
    localparam int DIM_W      = 7;
    localparam int GAMMA_W    = 17;
    localparam int REW_W      = 24;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int DIR_W      = 2;

    // Row/column divider: two quotient bits per step
    localparam int DIV_STEPS  = (Y_W + 1) / 2;
    localparam int QUOT_W     = 2 * DIV_STEPS;
    localparam int DVS_W      = DIM_W + QUOT_W;
    localparam int DIV_IDX_W  = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    // Fixed-point arithmetic
    localparam int FRAC_SH    = 16;
    localparam int ONE_Q16    = 1 << FRAC_SH;
    localparam int HALF_Q16   = 1 << (FRAC_SH - 1);
    localparam int GP_W       = GAMMA_W + Q_BITS - 1;
    localparam int P_W        = GP_W + 1 - FRAC_SH;
    localparam int TS_W       = ((P_W > REW_W) ? P_W : REW_W) + 2;
    localparam int AP_W       = GAMMA_W + 1 + Q_BITS + 1 + 1;
    localparam int D_W        = AP_W - FRAC_SH;
    localparam int NS_W       = D_W + 1;
    localparam int SAT_W      = (NS_W > TS_W) ? NS_W : TS_W;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GOAL_CELL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_CELL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LEARN_RATE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GOAL_REWARD = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_REWARD = 3'd7;

    // Reset values
    localparam logic [DIM_W-1:0]   WIDTH_RST       = 7'd64;
    localparam logic [DIM_W-1:0]   HEIGHT_RST      = 7'd64;
    localparam logic [CELL_W-1:0]  GOAL_RST        = 12'd0;
    localparam logic [CELL_W-1:0]  START_RST       = 12'd0;
    localparam logic [GAMMA_W-1:0] DISCOUNT_RST    = 17'd58982;
    localparam logic [GAMMA_W-1:0] LEARN_RATE_RST  = 17'd65536;
    localparam logic [REW_W-1:0]   GOAL_REWARD_RST = 24'd25600;
    localparam logic [REW_W-1:0]   STEP_REWARD_RST = 24'hFFFF00;

    // Move directions
    localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd0;
    localparam logic [DIR_W-1:0] DIR_UP    = 2'd1;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd2;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd3;

    // Configuration as seen by the datapath, sizes and rates already clamped
    typedef struct packed {
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [CELL_W-1:0]  goal;
        logic [CELL_W-1:0]  start;
        logic [GAMMA_W-1:0] gamma;
        logic [GAMMA_W-1:0] alpha;
        logic [REW_W-1:0]   goal_reward;
        logic [REW_W-1:0]   step_reward;
    } cfg_t;

    typedef struct packed {
        logic                 clr_wr;
        logic                 load;
        logic                 area;
        logic                 div_step;
        logic [DIV_IDX_W-1:0] div_idx;
        logic                 move;
        logic                 rd_land;
        logic                 rd_from;
        logic                 mul_g;
        logic                 tgt;
        logic                 mul_a;
        logic                 qnew;
        logic                 wb;
        logic                 out_load;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic out_free;
    } sts_t;

endpackage

// ===== src/gridworld_q_learning_step.sv =====
// Gridworld Q-learning step: each input beat carries one move direction; the block moves the
// agent, updates Q(from, dir) and returns one result beat with the cells, flags and new Q value.
// After reset a clearing pass zeroes the 4096-row Q memory with s_ready low; cfg_ready is
// always high. One item is in flight at a time, and s_ready stays low until its result is
// loaded: a restoring divider splits the cell into row and column, the single Q memory read
// port reads the landed row and then the current row, and the discount and learning-rate
// multiplies each sit in a state of their own before the write-back. A result waiting on m_ready
// holds the block only once the following item is finished.
// Depends on gqls_pkg, gqls_cfg, gqls_ctrl and gqls_dp.
module gridworld_q_learning_step (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [gqls_pkg::DIR_W-1:0]         s_move_dir,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [gqls_pkg::CELL_W-1:0]        m_from_cell,
    output logic [gqls_pkg::CELL_W-1:0]        m_landed_cell,
    output logic                               m_blocked,
    output logic                               m_reached_goal,
    output logic signed [gqls_pkg::Q_BITS-1:0] m_new_q_value,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [gqls_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gqls_pkg::CFG_DATA_W-1:0]    cfg_data
);

    gqls_pkg::cfg_t cfg;
    gqls_pkg::cmd_t cmd;
    gqls_pkg::sts_t sts;

    gqls_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    gqls_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    gqls_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .cfg            (cfg),
        .s_move_dir     (s_move_dir),
        .m_ready        (m_ready),
        .sts            (sts),
        .m_valid        (m_valid),
        .m_from_cell    (m_from_cell),
        .m_landed_cell  (m_landed_cell),
        .m_blocked      (m_blocked),
        .m_reached_goal (m_reached_goal),
        .m_new_q_value  (m_new_q_value)
    );

endmodule

// ===== src/gqls_cfg.sv =====
// Configuration register bank: decodes register writes and clamps sizes and rates.
// Depends on gqls_pkg.
module gqls_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gqls_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gqls_pkg::CFG_DATA_W-1:0]  cfg_data,
    output gqls_pkg::cfg_t                   cfg
);

    logic [gqls_pkg::DIM_W-1:0]   width_reg;
    logic [gqls_pkg::DIM_W-1:0]   height_reg;
    logic [gqls_pkg::CELL_W-1:0]  goal_reg;
    logic [gqls_pkg::CELL_W-1:0]  start_reg;
    logic [gqls_pkg::GAMMA_W-1:0] gamma_reg;
    logic [gqls_pkg::GAMMA_W-1:0] alpha_reg;
    logic [gqls_pkg::REW_W-1:0]   goal_rew_reg;
    logic [gqls_pkg::REW_W-1:0]   step_rew_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= gqls_pkg::WIDTH_RST;
            height_reg   <= gqls_pkg::HEIGHT_RST;
            goal_reg     <= gqls_pkg::GOAL_RST;
            start_reg    <= gqls_pkg::START_RST;
            gamma_reg    <= gqls_pkg::DISCOUNT_RST;
            alpha_reg    <= gqls_pkg::LEARN_RATE_RST;
            goal_rew_reg <= gqls_pkg::GOAL_REWARD_RST;
            step_rew_reg <= gqls_pkg::STEP_REWARD_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                gqls_pkg::REG_GRID_WIDTH:  width_reg    <= cfg_data[gqls_pkg::DIM_W-1:0];
                gqls_pkg::REG_GRID_HEIGHT: height_reg   <= cfg_data[gqls_pkg::DIM_W-1:0];
                gqls_pkg::REG_GOAL_CELL:   goal_reg     <= cfg_data[gqls_pkg::CELL_W-1:0];
                gqls_pkg::REG_START_CELL:  start_reg    <= cfg_data[gqls_pkg::CELL_W-1:0];
                gqls_pkg::REG_DISCOUNT:    gamma_reg    <= cfg_data[gqls_pkg::GAMMA_W-1:0];
                gqls_pkg::REG_LEARN_RATE:  alpha_reg    <= cfg_data[gqls_pkg::GAMMA_W-1:0];
                gqls_pkg::REG_GOAL_REWARD: goal_rew_reg <= cfg_data[gqls_pkg::REW_W-1:0];
                gqls_pkg::REG_STEP_REWARD: step_rew_reg <= cfg_data[gqls_pkg::REW_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp grid size to 1..max and rates to 1.0
    always_comb begin
        cfg.goal        = goal_reg;
        cfg.start       = start_reg;
        cfg.goal_reward = goal_rew_reg;
        cfg.step_reward = step_rew_reg;

        if (width_reg == '0) begin
            cfg.width = gqls_pkg::DIM_W'(1);
        end else if (width_reg > gqls_pkg::DIM_W'(gqls_pkg::MAX_WIDTH)) begin
            cfg.width = gqls_pkg::DIM_W'(gqls_pkg::MAX_WIDTH);
        end else begin
            cfg.width = width_reg;
        end

        if (height_reg == '0) begin
            cfg.height = gqls_pkg::DIM_W'(1);
        end else if (height_reg > gqls_pkg::DIM_W'(gqls_pkg::MAX_HEIGHT)) begin
            cfg.height = gqls_pkg::DIM_W'(gqls_pkg::MAX_HEIGHT);
        end else begin
            cfg.height = height_reg;
        end

        if (gamma_reg > gqls_pkg::GAMMA_W'(gqls_pkg::ONE_Q16)) begin
            cfg.gamma = gqls_pkg::GAMMA_W'(gqls_pkg::ONE_Q16);
        end else begin
            cfg.gamma = gamma_reg;
        end

        if (alpha_reg > gqls_pkg::GAMMA_W'(gqls_pkg::ONE_Q16)) begin
            cfg.alpha = gqls_pkg::GAMMA_W'(gqls_pkg::ONE_Q16);
        end else begin
            cfg.alpha = alpha_reg;
        end
    end

endmodule

// ===== src/gqls_ctrl.sv =====
// Sequencer for one Q-learning step: clearing pass, divide, move, Q reads, update, write-back.
// Depends on gqls_pkg; drives the datapath through cmd_t and watches sts_t.
module gqls_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  gqls_pkg::sts_t sts,
    output gqls_pkg::cmd_t cmd
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_AREA  = 4'd2;
    localparam logic [3:0] S_DIV   = 4'd3;
    localparam logic [3:0] S_MOVE  = 4'd4;
    localparam logic [3:0] S_RDL   = 4'd5;
    localparam logic [3:0] S_RDF   = 4'd6;
    localparam logic [3:0] S_MULG  = 4'd7;
    localparam logic [3:0] S_TGT   = 4'd8;
    localparam logic [3:0] S_MULA  = 4'd9;
    localparam logic [3:0] S_NEW   = 4'd10;
    localparam logic [3:0] S_WB    = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    logic [3:0]                     state_reg;
    logic [3:0]                     state_next;
    logic [gqls_pkg::DIV_IDX_W-1:0] div_cnt_reg;
    logic [gqls_pkg::DIV_IDX_W-1:0] div_cnt_next;

    assign s_ready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            div_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        cmd.div_idx  = div_cnt_reg;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_AREA;
                end
            end
            S_AREA: begin
                cmd.area     = 1'b1;
                div_cnt_next = gqls_pkg::DIV_IDX_W'(gqls_pkg::DIV_STEPS - 1);
                state_next   = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (div_cnt_reg == '0) begin
                    state_next = S_MOVE;
                end else begin
                    div_cnt_next = div_cnt_reg - gqls_pkg::DIV_IDX_W'(1);
                end
            end
            S_MOVE: begin
                cmd.move   = 1'b1;
                state_next = S_RDL;
            end
            S_RDL: begin
                cmd.rd_land = 1'b1;
                state_next  = S_RDF;
            end
            S_RDF: begin
                cmd.rd_from = 1'b1;
                state_next  = S_MULG;
            end
            S_MULG: begin
                cmd.mul_g  = 1'b1;
                state_next = S_TGT;
            end
            S_TGT: begin
                cmd.tgt    = 1'b1;
                state_next = S_MULA;
            end
            S_MULA: begin
                cmd.mul_a  = 1'b1;
                state_next = S_NEW;
            end
            S_NEW: begin
                cmd.qnew   = 1'b1;
                state_next = S_WB;
            end
            S_WB: begin
                cmd.wb     = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                // hold until the result register is free
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

// ===== src/gqls_dp.sv =====
// Datapath: agent cell, row/column divider, move logic, Q memory, update arithmetic, result register.
// Depends on gqls_pkg; sequenced by gqls_ctrl through cmd_t.
module gqls_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  gqls_pkg::cmd_t                    cmd,
    input  gqls_pkg::cfg_t                    cfg,
    input  logic [gqls_pkg::DIR_W-1:0]        s_move_dir,
    input  logic                              m_ready,
    output gqls_pkg::sts_t                    sts,
    output logic                              m_valid,
    output logic [gqls_pkg::CELL_W-1:0]       m_from_cell,
    output logic [gqls_pkg::CELL_W-1:0]       m_landed_cell,
    output logic                              m_blocked,
    output logic                              m_reached_goal,
    output logic signed [gqls_pkg::Q_BITS-1:0] m_new_q_value
);

    localparam int DIM_W  = gqls_pkg::DIM_W;
    localparam int CELL_W = gqls_pkg::CELL_W;
    localparam int Q_BITS = gqls_pkg::Q_BITS;
    localparam int DVS_W  = gqls_pkg::DVS_W;
    localparam int QUOT_W = gqls_pkg::QUOT_W;
    localparam int GP_W   = gqls_pkg::GP_W;
    localparam int P_W    = gqls_pkg::P_W;
    localparam int TS_W   = gqls_pkg::TS_W;
    localparam int AP_W   = gqls_pkg::AP_W;
    localparam int D_W    = gqls_pkg::D_W;
    localparam int NS_W   = gqls_pkg::NS_W;
    localparam int SAT_W  = gqls_pkg::SAT_W;
    localparam int REW_W  = gqls_pkg::REW_W;
    localparam int ROW_W  = gqls_pkg::ROW_W;

    function automatic logic [Q_BITS-1:0] sat_q(input logic [SAT_W-1:0] v);
        logic [SAT_W-Q_BITS:0] top;
        top = v[SAT_W-1:Q_BITS-1];
        if (top == '0 || top == '1) begin
            return v[Q_BITS-1:0];
        end else if (v[SAT_W-1]) begin
            return {1'b1, {(Q_BITS-1){1'b0}}};
        end else begin
            return {1'b0, {(Q_BITS-1){1'b1}}};
        end
    endfunction

    // Item and control state
    logic [gqls_pkg::DIR_W-1:0] dir_reg;
    logic [CELL_W-1:0]          from_reg;
    logic [CELL_W-1:0]          agent_reg;
    logic                       out_grid_reg;
    logic [CELL_W-1:0]          rem_reg;
    logic [QUOT_W-1:0]          quot_reg;
    logic [CELL_W-1:0]          landed_reg;
    logic                       blocked_reg;
    logic                       goal_reg;
    logic [REW_W-1:0]           reward_reg;
    logic signed [Q_BITS-1:0]   maxq_reg;
    logic signed [Q_BITS-1:0]   qold_reg;
    logic [ROW_W-1:0]           row_reg;
    logic [GP_W-1:0]            gprod_reg;
    logic signed [Q_BITS-1:0]   target_reg;
    logic signed [AP_W-1:0]     aprod_reg;
    logic signed [Q_BITS-1:0]   qnew_reg;
    logic [CELL_W-1:0]          clr_addr_reg;

    // Q memory, one row of four action values per cell
    logic [ROW_W-1:0]           q_mem [gqls_pkg::N_CELLS];
    logic [ROW_W-1:0]           rdata_reg;
    logic                       mem_we;
    logic [CELL_W-1:0]          mem_waddr;
    logic [CELL_W-1:0]          mem_raddr;
    logic [ROW_W-1:0]           mem_wdata;
    logic [ROW_W-1:0]           wb_row;

    // Result register
    logic                       m_valid_reg;
    logic [CELL_W-1:0]          m_from_reg;
    logic [CELL_W-1:0]          m_landed_reg;
    logic                       m_blocked_reg;
    logic                       m_goal_reg;
    logic signed [Q_BITS-1:0]   m_q_reg;

    // Combinational next values
    logic [2*DIM_W-1:0]         area;
    logic                       out_grid_next;
    logic [gqls_pkg::DIV_IDX_W:0] bit_hi;
    logic [gqls_pkg::DIV_IDX_W:0] bit_lo;
    logic [DVS_W-1:0]           dvs_hi;
    logic [DVS_W-1:0]           dvs_lo;
    logic [DVS_W-1:0]           rem_ext;
    logic [DVS_W-1:0]           rem_mid;
    logic [DVS_W-1:0]           rem_fin;
    logic                       q_hi;
    logic                       q_lo;
    logic [DIM_W-1:0]           x_cur;
    logic [DIM_W-1:0]           y_cur;
    logic [DIM_W-1:0]           x_new;
    logic [DIM_W-1:0]           y_new;
    logic                       blk;
    logic [2*DIM_W-1:0]         lin;
    logic [CELL_W-1:0]          landed_next;
    logic                       blocked_next;
    logic                       goal_next;
    logic signed [Q_BITS-1:0]   qe [gqls_pkg::N_ACT];
    logic signed [Q_BITS-1:0]   m01;
    logic signed [Q_BITS-1:0]   m23;
    logic signed [Q_BITS-1:0]   m03;
    logic signed [Q_BITS-1:0]   maxq_next;
    logic [GP_W-1:0]            gprod_next;
    logic [GP_W:0]              gsum;
    logic [P_W-1:0]             p_val;
    logic signed [TS_W-1:0]     tsum;
    logic signed [Q_BITS:0]     diff;
    logic signed [GP_W-GP_W+gqls_pkg::GAMMA_W:0] alpha_s;
    logic signed [AP_W-1:0]     aprod_next;
    logic signed [AP_W-1:0]     asum;
    logic signed [D_W-1:0]      delta;
    logic signed [NS_W-1:0]     nsum;

    assign area          = (2*DIM_W)'(cfg.width) * (2*DIM_W)'(cfg.height);
    assign out_grid_next = (2*DIM_W)'(from_reg) >= area;

    // Two restoring-divide steps per cycle: row = from / width, column = remainder
    assign bit_hi  = {cmd.div_idx, 1'b1};
    assign bit_lo  = {cmd.div_idx, 1'b0};
    assign dvs_hi  = DVS_W'(cfg.width) << bit_hi;
    assign dvs_lo  = DVS_W'(cfg.width) << bit_lo;
    assign rem_ext = DVS_W'(rem_reg);
    assign q_hi    = rem_ext >= dvs_hi;
    assign rem_mid = q_hi ? rem_ext - dvs_hi : rem_ext;
    assign q_lo    = rem_mid >= dvs_lo;
    assign rem_fin = q_lo ? rem_mid - dvs_lo : rem_mid;

    assign x_cur = DIM_W'(rem_reg[gqls_pkg::X_W-1:0]);
    assign y_cur = DIM_W'(quot_reg[gqls_pkg::Y_W-1:0]);

    always_comb begin
        x_new = x_cur;
        y_new = y_cur;
        blk   = 1'b0;
        case (dir_reg)
            gqls_pkg::DIR_RIGHT: begin
                if (x_cur + DIM_W'(1) < cfg.width) x_new = x_cur + DIM_W'(1);
                else blk = 1'b1;
            end
            gqls_pkg::DIR_UP: begin
                if (y_cur + DIM_W'(1) < cfg.height) y_new = y_cur + DIM_W'(1);
                else blk = 1'b1;
            end
            gqls_pkg::DIR_LEFT: begin
                if (x_cur != '0) x_new = x_cur - DIM_W'(1);
                else blk = 1'b1;
            end
            gqls_pkg::DIR_DOWN: begin
                if (y_cur != '0) y_new = y_cur - DIM_W'(1);
                else blk = 1'b1;
            end
            default: blk = 1'b0;
        endcase
    end

    assign lin          = (2*DIM_W)'(y_new) * (2*DIM_W)'(cfg.width) + (2*DIM_W)'(x_new);
    // An agent outside the grid lands on cell zero and is never blocked
    assign landed_next  = out_grid_reg ? '0 : lin[CELL_W-1:0];
    assign blocked_next = out_grid_reg ? 1'b0 : blk;
    assign goal_next    = (landed_reg == cfg.goal);

    always_comb begin
        for (int a = 0; a < gqls_pkg::N_ACT; a++) begin
            qe[a] = $signed(rdata_reg[a*Q_BITS +: Q_BITS]);
        end
    end

    assign m01       = (qe[0] > qe[1]) ? qe[0] : qe[1];
    assign m23       = (qe[2] > qe[3]) ? qe[2] : qe[3];
    assign m03       = (m01 > m23) ? m01 : m23;
    assign maxq_next = (m03 > 0) ? m03 : '0;

    // maxq is never negative here, so the discount product is unsigned
    assign gprod_next = GP_W'(cfg.gamma) * GP_W'(maxq_reg[Q_BITS-2:0]);
    assign gsum       = {1'b0, gprod_reg} + (GP_W+1)'(gqls_pkg::HALF_Q16);
    assign p_val      = gsum[GP_W:gqls_pkg::FRAC_SH];
    assign tsum       = $signed({{(TS_W-REW_W){reward_reg[REW_W-1]}}, reward_reg})
                      + $signed({{(TS_W-P_W){1'b0}}, p_val});

    assign diff       = $signed({target_reg[Q_BITS-1], target_reg})
                      - $signed({qold_reg[Q_BITS-1], qold_reg});
    assign alpha_s    = $signed({1'b0, cfg.alpha});
    assign aprod_next = alpha_s * diff;
    assign asum       = aprod_reg + $signed(AP_W'(gqls_pkg::HALF_Q16));
    assign delta      = $signed(asum[AP_W-1:gqls_pkg::FRAC_SH]);
    assign nsum       = $signed({{(NS_W-Q_BITS){qold_reg[Q_BITS-1]}}, qold_reg})
                      + $signed({delta[D_W-1], delta});

    always_comb begin
        wb_row = row_reg;
        wb_row[dir_reg*Q_BITS +: Q_BITS] = qnew_reg;
    end

    assign mem_we    = cmd.clr_wr | cmd.wb;
    assign mem_waddr = cmd.clr_wr ? clr_addr_reg : from_reg;
    assign mem_wdata = cmd.clr_wr ? '0 : wb_row;
    assign mem_raddr = cmd.rd_from ? from_reg : landed_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            q_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= q_mem[mem_raddr];
    end

    // Control state with reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            agent_reg    <= gqls_pkg::START_RST;
            clr_addr_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.clr_wr) begin
                clr_addr_reg <= clr_addr_reg + CELL_W'(1);
            end
            if (cmd.wb) begin
                agent_reg <= goal_reg ? cfg.start : landed_reg;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            dir_reg  <= s_move_dir;
            from_reg <= agent_reg;
        end
        if (cmd.area) begin
            out_grid_reg <= out_grid_next;
            rem_reg      <= from_reg;
            quot_reg     <= '0;
        end
        if (cmd.div_step) begin
            rem_reg  <= rem_fin[CELL_W-1:0];
            quot_reg <= {quot_reg[QUOT_W-3:0], q_hi, q_lo};
        end
        if (cmd.move) begin
            landed_reg  <= landed_next;
            blocked_reg <= blocked_next;
        end
        if (cmd.rd_land) begin
            goal_reg   <= goal_next;
            reward_reg <= goal_next ? cfg.goal_reward : cfg.step_reward;
        end
        if (cmd.rd_from) begin
            maxq_reg <= maxq_next;
        end
        if (cmd.mul_g) begin
            qold_reg  <= $signed(rdata_reg[dir_reg*Q_BITS +: Q_BITS]);
            row_reg   <= rdata_reg;
            gprod_reg <= gprod_next;
        end
        if (cmd.tgt) begin
            target_reg <= $signed(sat_q({{(SAT_W-TS_W){tsum[TS_W-1]}}, tsum}));
        end
        if (cmd.mul_a) begin
            aprod_reg <= aprod_next;
        end
        if (cmd.qnew) begin
            qnew_reg <= $signed(sat_q({{(SAT_W-NS_W){nsum[NS_W-1]}}, nsum}));
        end
        if (cmd.out_load) begin
            m_from_reg    <= from_reg;
            m_landed_reg  <= landed_reg;
            m_blocked_reg <= blocked_reg;
            m_goal_reg    <= goal_reg;
            m_q_reg       <= qnew_reg;
        end
    end

    assign sts.clr_last = (clr_addr_reg == CELL_W'(gqls_pkg::N_CELLS - 1));
    assign sts.out_free = !m_valid_reg || m_ready;

    assign m_valid        = m_valid_reg;
    assign m_from_cell    = m_from_reg;
    assign m_landed_cell  = m_landed_reg;
    assign m_blocked      = m_blocked_reg;
    assign m_reached_goal = m_goal_reg;
    assign m_new_q_value  = m_q_reg;

endmodule

// ===== src/gqls_chk.sv =====
// Port-level checker for gridworld_q_learning_step, attached by the bind at the end of the file.
// Depends on gqls_pkg.
module gqls_chk (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic [gqls_pkg::CELL_W-1:0]        m_from_cell,
    input logic [gqls_pkg::CELL_W-1:0]        m_landed_cell,
    input logic                               m_blocked,
    input logic signed [gqls_pkg::Q_BITS-1:0] m_new_q_value
);

    // reset starts the clearing pass: no input taken, no result shown
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("input ready or result valid right after reset");

    // one item in flight: an accepted beat drops ready on the next edge
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second beat taken while an item is in progress");

    // a blocked move leaves the agent where it was
    a_blocked_stays: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_blocked |-> m_landed_cell == m_from_cell)
        else $error("blocked move reports a different landed cell");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_new_q_value) && $stable(m_landed_cell))
        else $error("stalled result beat changed or dropped");

endmodule

bind gridworld_q_learning_step gqls_chk u_gqls_chk (.*);
